// ===== hw/rtl/mhad_pkg.sv =====
// ----------------------------------------------------------------------------
// mhad_pkg: shared types and constants for the magnetic heading block
// Widths of the normalized vector, the CORDIC datapath and the angle
// accumulator, the stage payload types and the arctangent table.
// ----------------------------------------------------------------------------
package mhad_pkg;

  localparam int AXIS_BITS_DEF = 16;
  localparam int NORM_W        = 41;
  localparam int NORM_STAGES   = 6;
  localparam int CORDIC_STEPS  = 24;
  localparam int CW            = 45;
  localparam int ACC_W         = 28;
  localparam int ANGLE_W       = 27;
  localparam int FRAC_BITS     = 20;
  localparam int HEAD_W        = 9;
  localparam int QUAD_W        = 7;
  localparam int STEP_W        = 5;

  localparam logic [HEAD_W-1:0] HEAD_0   = HEAD_W'(0);
  localparam logic [HEAD_W-1:0] HEAD_90  = HEAD_W'(90);
  localparam logic [HEAD_W-1:0] HEAD_180 = HEAD_W'(180);
  localparam logic [HEAD_W-1:0] HEAD_270 = HEAD_W'(270);
  localparam logic [HEAD_W-1:0] HEAD_360 = HEAD_W'(360);

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(90 * (2 ** FRAC_BITS) - 1);

  typedef struct packed {
    logic              axis;
    logic [HEAD_W-1:0] base;
    logic [NORM_W-1:0] ux;
    logic [NORM_W-1:0] uw;
  } norm_t;

  typedef struct packed {
    logic                     axis;
    logic [HEAD_W-1:0]        base;
    logic signed [CW-1:0]     x;
    logic signed [CW-1:0]     w;
    logic signed [ACC_W-1:0]  acc;
  } cordic_t;

  // Arctangent of 2^-i in degrees, unsigned Q20, rounded to nearest.
  function automatic logic [ANGLE_W-1:0] atan_q20(input logic [STEP_W-1:0] idx);
    logic [ANGLE_W-1:0] r;
    case (idx)
      5'd0:    r = 27'd47185920;
      5'd1:    r = 27'd27855475;
      5'd2:    r = 27'd14718068;
      5'd3:    r = 27'd7471121;
      5'd4:    r = 27'd3750058;
      5'd5:    r = 27'd1876857;
      5'd6:    r = 27'd938658;
      5'd7:    r = 27'd469357;
      5'd8:    r = 27'd234682;
      5'd9:    r = 27'd117342;
      5'd10:   r = 27'd58671;
      5'd11:   r = 27'd29335;
      5'd12:   r = 27'd14668;
      5'd13:   r = 27'd7334;
      5'd14:   r = 27'd3667;
      5'd15:   r = 27'd1833;
      5'd16:   r = 27'd917;
      5'd17:   r = 27'd458;
      5'd18:   r = 27'd229;
      5'd19:   r = 27'd115;
      5'd20:   r = 27'd57;
      5'd21:   r = 27'd29;
      5'd22:   r = 27'd14;
      5'd23:   r = 27'd7;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/mhad_norm_cell.sv =====
// ----------------------------------------------------------------------------
// mhad_norm_cell: one stage of the normalizing shifter
// Shifts both components left by SHIFT when the top SHIFT bits of the
// larger one are all zero, then registers the result for the next cell.
// ----------------------------------------------------------------------------
module mhad_norm_cell #(
  parameter int SHIFT = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  mhad_pkg::norm_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output mhad_pkg::norm_t dn_data
);
  import mhad_pkg::*;

  logic [NORM_W-1:0] big;
  norm_t             nxt;

  assign big      = (up_data.ux > up_data.uw) ? up_data.ux : up_data.uw;
  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    nxt = up_data;
    if (big[NORM_W-1 -: SHIFT] == '0) begin
      nxt.ux = up_data.ux << SHIFT;
      nxt.uw = up_data.uw << SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_data <= nxt;
    end
  end

endmodule

// ===== hw/rtl/mhad_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// mhad_cordic_cell: one vectoring CORDIC iteration
// Rotates the vector toward the x axis by atan(2^-STEP) and adds the
// rotation to the angle accumulator, then registers the result.
// ----------------------------------------------------------------------------
module mhad_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  mhad_pkg::cordic_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output mhad_pkg::cordic_t dn_data
);
  import mhad_pkg::*;

  localparam logic [ACC_W-1:0] ANGLE = {1'b0, atan_q20(STEP_W'(STEP))};

  logic signed [CW-1:0] x_cur;
  logic signed [CW-1:0] w_cur;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ws;
  logic                 w_pos;
  logic                 w_neg;
  cordic_t              nxt;

  assign x_cur    = up_data.x;
  assign w_cur    = up_data.w;
  assign xs       = x_cur >>> STEP;
  assign ws       = w_cur >>> STEP;
  assign w_neg    = w_cur[CW-1];
  assign w_pos    = !w_cur[CW-1] && (w_cur != '0);
  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    nxt = up_data;
    if (w_pos) begin
      nxt.x   = x_cur + ws;
      nxt.w   = w_cur - xs;
      nxt.acc = up_data.acc + ANGLE;
    end else if (w_neg) begin
      nxt.x   = x_cur - ws;
      nxt.w   = w_cur + xs;
      nxt.acc = up_data.acc - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_data <= nxt;
    end
  end

endmodule

// ===== hw/rtl/magnetic_heading_atan2_degrees.sv =====
// ----------------------------------------------------------------------------
// magnetic_heading_atan2_degrees: compass heading from a magnetometer sample
//
//   Channel   Signals                        Direction  Content
//   mag       mag_valid mag_ready mag_y mag_z  in        one field sample
//   heading   heading_valid heading_ready    out        heading_deg, 0..359
//                heading_deg
//
// One sample is accepted per cycle unless the receiver stalls the output. The
// pipeline holds a quadrant fold register, six normalizing shifter cells,
// 24 CORDIC cells and the output register. Each cell stalls only when it is
// full and its successor is full and stalled. Reset empties the pipeline.
// ----------------------------------------------------------------------------
module magnetic_heading_atan2_degrees #(
  parameter int AXIS_BITS = mhad_pkg::AXIS_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        mag_valid,
  output logic                        mag_ready,
  input  logic signed [AXIS_BITS-1:0] mag_y,
  input  logic signed [AXIS_BITS-1:0] mag_z,
  output logic                        heading_valid,
  input  logic                        heading_ready,
  output logic [mhad_pkg::HEAD_W-1:0] heading_deg
);
  import mhad_pkg::*;

  logic                    y_neg;
  logic                    z_neg;
  logic                    y_zero;
  logic                    z_zero;
  logic [AXIS_BITS:0]      y_neg_val;
  logic [AXIS_BITS:0]      z_neg_val;
  logic [AXIS_BITS-1:0]    ay;
  logic [AXIS_BITS-1:0]    az;
  logic [NORM_W-1:0]       ay_ext;
  logic [NORM_W-1:0]       az_ext;
  norm_t                   fold;

  norm_t                   norm_d [NORM_STAGES+1];
  logic                    norm_v [NORM_STAGES+1];
  logic                    norm_r [NORM_STAGES+1];
  cordic_t                 cordic_d [CORDIC_STEPS+1];
  logic                    cordic_v [CORDIC_STEPS+1];
  logic                    cordic_r [CORDIC_STEPS+1];

  cordic_t                 last;
  logic signed [ACC_W-1:0] acc_clamped;
  logic [QUAD_W-1:0]       quad_deg;
  logic [HEAD_W-1:0]       heading_next;

  // Quadrant fold: both components of the turned vector are non-negative.
  assign y_neg     = mag_y[AXIS_BITS-1];
  assign z_neg     = mag_z[AXIS_BITS-1];
  assign y_zero    = (mag_y == '0);
  assign z_zero    = (mag_z == '0);
  assign y_neg_val = -{mag_y[AXIS_BITS-1], mag_y};
  assign z_neg_val = -{mag_z[AXIS_BITS-1], mag_z};
  assign ay        = y_neg ? y_neg_val[AXIS_BITS-1:0] : mag_y;
  assign az        = z_neg ? z_neg_val[AXIS_BITS-1:0] : mag_z;
  assign ay_ext    = {{(NORM_W-AXIS_BITS){1'b0}}, ay};
  assign az_ext    = {{(NORM_W-AXIS_BITS){1'b0}}, az};

  always_comb begin
    fold.axis = y_zero || z_zero;
    if (y_neg ^ z_neg) begin
      fold.ux = ay_ext;
      fold.uw = az_ext;
    end else begin
      fold.ux = az_ext;
      fold.uw = ay_ext;
    end
    if (y_zero && z_zero) begin
      fold.base = HEAD_0;
    end else if (y_zero) begin
      fold.base = z_neg ? HEAD_180 : HEAD_0;
    end else if (z_zero) begin
      fold.base = y_neg ? HEAD_270 : HEAD_90;
    end else if (!y_neg && !z_neg) begin
      fold.base = HEAD_0;
    end else if (!y_neg) begin
      fold.base = HEAD_90;
    end else if (z_neg) begin
      fold.base = HEAD_180;
    end else begin
      fold.base = HEAD_270;
    end
  end

  assign mag_ready = !norm_v[0] || norm_r[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_v[0] <= 1'b0;
    end else if (mag_ready) begin
      norm_v[0] <= mag_valid;
    end
    if (mag_ready && mag_valid) begin
      norm_d[0] <= fold;
    end
  end

  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    mhad_norm_cell #(
      .SHIFT(2 ** (NORM_STAGES - 1 - k))
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_valid(norm_v[k]),
      .up_ready(norm_r[k]),
      .up_data (norm_d[k]),
      .dn_valid(norm_v[k+1]),
      .dn_ready(norm_r[k+1]),
      .dn_data (norm_d[k+1])
    );
  end

  always_comb begin
    cordic_d[0].axis = norm_d[NORM_STAGES].axis;
    cordic_d[0].base = norm_d[NORM_STAGES].base;
    cordic_d[0].x    = {{(CW-NORM_W){1'b0}}, norm_d[NORM_STAGES].ux};
    cordic_d[0].w    = {{(CW-NORM_W){1'b0}}, norm_d[NORM_STAGES].uw};
    cordic_d[0].acc  = '0;
  end
  assign cordic_v[0]           = norm_v[NORM_STAGES];
  assign norm_r[NORM_STAGES]   = cordic_r[0];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    mhad_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_valid(cordic_v[i]),
      .up_ready(cordic_r[i]),
      .up_data (cordic_d[i]),
      .dn_valid(cordic_v[i+1]),
      .dn_ready(cordic_r[i+1]),
      .dn_data (cordic_d[i+1])
    );
  end

  assign last                   = cordic_d[CORDIC_STEPS];
  assign cordic_r[CORDIC_STEPS] = !heading_valid || heading_ready;

  always_comb begin
    if (last.acc[ACC_W-1]) begin
      acc_clamped = '0;
    end else if (last.acc > ACC_MAX) begin
      acc_clamped = ACC_MAX;
    end else begin
      acc_clamped = last.acc;
    end
  end

  assign quad_deg     = acc_clamped[FRAC_BITS +: QUAD_W];
  assign heading_next = last.axis ? last.base : last.base + {2'b00, quad_deg};

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_valid <= 1'b0;
    end else if (cordic_r[CORDIC_STEPS]) begin
      heading_valid <= cordic_v[CORDIC_STEPS];
    end
    if (cordic_r[CORDIC_STEPS] && cordic_v[CORDIC_STEPS]) begin
      heading_deg <= heading_next;
    end
  end

endmodule

// ===== hw/rtl/mhad_checker.sv =====
// ----------------------------------------------------------------------------
// mhad_checker: port-level assertions for the magnetic heading block
// Checks the heading range, output stability under stall, reset
// behavior and that a free output never blocks the input.
// ----------------------------------------------------------------------------
module mhad_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        mag_valid,
  input logic                        mag_ready,
  input logic                        heading_valid,
  input logic                        heading_ready,
  input logic [mhad_pkg::HEAD_W-1:0] heading_deg
);
  import mhad_pkg::*;

  a_range : assert property (@(posedge clk) disable iff (rst)
    heading_valid |-> (heading_deg < HEAD_360))
    else $error("heading out of range");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    (heading_valid && !heading_ready) |=> (heading_valid && $stable(heading_deg)))
    else $error("stalled heading changed");

  a_reset : assert property (@(posedge clk)
    rst |=> !heading_valid)
    else $error("heading valid after reset");

  a_flow : assert property (@(posedge clk) disable iff (rst)
    (heading_ready || !heading_valid) |-> mag_ready)
    else $error("input blocked while output is free");

  a_idle : assert property (@(posedge clk) disable iff (rst)
    (!mag_valid && !heading_valid) |-> mag_ready)
    else $error("input blocked with empty output stage");

endmodule

bind magnetic_heading_atan2_degrees mhad_checker u_mhad_checker (
  .clk          (clk),
  .rst          (rst),
  .mag_valid    (mag_valid),
  .mag_ready    (mag_ready),
  .heading_valid(heading_valid),
  .heading_ready(heading_ready),
  .heading_deg  (heading_deg)
);

// ===== bench/tb_magnetic_heading_atan2_degrees.sv =====
// ----------------------------------------------------------------------------
// tb_magnetic_heading_atan2_degrees: testbench for the compass heading block
// Drives directed samples, then magnetometer samples in random bursts, against a stalling receiver.
// A scoreboard computes each expected heading with its own CORDIC and checks
// every result transfer in order.
// ----------------------------------------------------------------------------
module tb_magnetic_heading_atan2_degrees;

  localparam int AXIS_W     = mhad_pkg::AXIS_BITS_DEF;
  localparam int HW         = mhad_pkg::HEAD_W;
  localparam int N_RANDOM   = 1000;
  localparam int N_DIRECTED = 22;
  localparam int DRAIN_WAIT = 40;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PERIODIC,
    RDY_SPARSE
  } ready_mode_t;

  typedef struct {
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
    logic [HW-1:0]            heading;
  } heading_exp_t;

  class heading_scoreboard;
    heading_exp_t expected_q[$];
    int           errors;
    longint       atan_deg_q20[mhad_pkg::CORDIC_STEPS];

    function new();
      errors = 0;
      atan_deg_q20 = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458,
        229, 115, 57, 29, 14, 7
      };
    endfunction

    function longint quadrant_deg(longint ux, longint uw);
      longint x;
      longint w;
      longint xs;
      longint ws;
      longint acc;
      longint acc_max;
      acc = 0;
      acc_max = 90 * (longint'(1) << mhad_pkg::FRAC_BITS) - 1;
      while ((ux > uw ? ux : uw) < (longint'(1) << 40)) begin
        ux = ux << 1;
        uw = uw << 1;
      end
      x = ux;
      w = uw;
      for (int i = 0; i < mhad_pkg::CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ws = w >>> i;
        if (w > 0) begin
          x = x + ws;
          w = w - xs;
          acc = acc + atan_deg_q20[i];
        end else if (w < 0) begin
          x = x - ws;
          w = w + xs;
          acc = acc - atan_deg_q20[i];
        end
      end
      if (acc < 0) acc = 0;
      if (acc > acc_max) acc = acc_max;
      return acc >>> mhad_pkg::FRAC_BITS;
    endfunction

    function logic [HW-1:0] heading_of(logic signed [AXIS_W-1:0] y,
                                       logic signed [AXIS_W-1:0] z);
      longint yy;
      longint zz;
      longint h;
      yy = y;
      zz = z;
      if (yy == 0 && zz == 0) begin
        h = mhad_pkg::HEAD_0;
      end else if (yy == 0) begin
        h = (zz > 0) ? mhad_pkg::HEAD_0 : mhad_pkg::HEAD_180;
      end else if (zz == 0) begin
        h = (yy > 0) ? mhad_pkg::HEAD_90 : mhad_pkg::HEAD_270;
      end else if (zz > 0 && yy > 0) begin
        h = mhad_pkg::HEAD_0 + quadrant_deg(zz, yy);
      end else if (zz < 0 && yy > 0) begin
        h = mhad_pkg::HEAD_90 + quadrant_deg(yy, -zz);
      end else if (zz < 0 && yy < 0) begin
        h = mhad_pkg::HEAD_180 + quadrant_deg(-zz, -yy);
      end else begin
        h = mhad_pkg::HEAD_270 + quadrant_deg(-yy, zz);
      end
      if (h >= mhad_pkg::HEAD_360) h = h - mhad_pkg::HEAD_360;
      return HW'(h);
    endfunction

    function void note_sample(logic signed [AXIS_W-1:0] y,
                              logic signed [AXIS_W-1:0] z);
      heading_exp_t e;
      e.y = y;
      e.z = z;
      e.heading = heading_of(y, z);
      expected_q.push_back(e);
    endfunction

    function void check_heading(logic [HW-1:0] got);
      heading_exp_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected heading transfer: expected none, actual %0d",
                 $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got !== e.heading) begin
        $display("%0t: heading mismatch for y=%0d z=%0d: expected %0d, actual %0d",
                 $time, e.y, e.z, e.heading, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     mag_valid = 1'b0;
  logic                     mag_ready;
  logic signed [AXIS_W-1:0] mag_y = '0;
  logic signed [AXIS_W-1:0] mag_z = '0;
  logic                     heading_valid;
  logic                     heading_ready = 1'b0;
  logic [HW-1:0]            heading_deg;

  ready_mode_t       ready_mode = RDY_ALWAYS;
  int                mode_left = 0;
  logic [31:0]       cyc = '0;
  heading_scoreboard sb = new();

  magnetic_heading_atan2_degrees dut (
    .clk           (clk),
    .rst           (rst),
    .mag_valid     (mag_valid),
    .mag_ready     (mag_ready),
    .mag_y         (mag_y),
    .mag_z         (mag_z),
    .heading_valid (heading_valid),
    .heading_ready (heading_ready),
    .heading_deg   (heading_deg)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS:   heading_ready <= 1'b1;
      RDY_RANDOM:   heading_ready <= 1'($urandom_range(0, 1));
      RDY_PERIODIC: heading_ready <= (cyc[2:0] != 3'd5) && (cyc[3:0] != 4'd2);
      default:      heading_ready <= (cyc[4:0] < 5'd4);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && heading_valid && heading_ready) begin
      sb.check_heading(heading_deg);
    end
  end

  task automatic send_sample(input logic signed [AXIS_W-1:0] y,
                             input logic signed [AXIS_W-1:0] z);
    mag_valid <= 1'b1;
    mag_y <= y;
    mag_z <= z;
    do @(posedge clk); while (!mag_ready);
    sb.note_sample(y, z);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      mag_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_all_headings();
    mag_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic pick_sample(output logic signed [AXIS_W-1:0] y,
                             output logic signed [AXIS_W-1:0] z);
    int   sel;
    int   m;
    logic signed [AXIS_W-1:0] edge_vals[7];
    edge_vals = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7ffe, 16'sh7fff};
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      y = AXIS_W'($urandom);
      z = AXIS_W'($urandom);
    end else if (sel < 55) begin
      y = AXIS_W'($urandom_range(0, 16) - 8);
      z = AXIS_W'($urandom_range(0, 16) - 8);
    end else if (sel < 70) begin
      if ($urandom_range(0, 1) == 1) begin
        y = AXIS_W'($urandom_range(0, 2) - 1);
        z = AXIS_W'($urandom);
      end else begin
        y = AXIS_W'($urandom);
        z = AXIS_W'($urandom_range(0, 2) - 1);
      end
    end else if (sel < 85) begin
      m = $urandom_range(1, 32767);
      y = ($urandom_range(0, 1) == 1) ? AXIS_W'(m) : AXIS_W'(-m);
      z = ($urandom_range(0, 1) == 1) ? AXIS_W'(m) : AXIS_W'(-m);
    end else begin
      y = edge_vals[$urandom_range(0, 6)];
      z = ($urandom_range(0, 1) == 1) ? edge_vals[$urandom_range(0, 6)]
                                       : AXIS_W'($urandom);
    end
  endtask

  initial begin
    int dir_y[N_DIRECTED] = '{0, 0, 1, 0, -1, 0, 32767, 0, -32768, 32767, -32768,
                              32767, -32768, 1, 1, -1, -1, 32767, 1, -1, -32768, 1};
    int dir_z[N_DIRECTED] = '{0, 1, 0, -1, 0, 32767, 0, -32768, 0, 32767, -32768,
                              -32768, 32767, 1, -1, -1, 1, 1, 32767, 32767, 1, -32768};
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
    int sent;
    int burst;
    int gap;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_sample(AXIS_W'(dir_y[i]), AXIS_W'(dir_z[i]));
      if (i % 5 == 4) idle_cycles($urandom_range(1, 6));
    end
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
        pick_sample(y, z);
        send_sample(y, z);
        sent++;
        if (sent == N_RANDOM / 2) wait_all_headings();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      idle_cycles(gap);
    end
    mag_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mhad_pkg.sv
hw/rtl/mhad_norm_cell.sv
hw/rtl/mhad_cordic_cell.sv
hw/rtl/magnetic_heading_atan2_degrees.sv
hw/rtl/mhad_checker.sv
bench/tb_magnetic_heading_atan2_degrees.sv
